>>> sv/nnys_pkg.sv
package nnys_pkg;

	// Frame geometry limits and address width.
	localparam int MAX_DIM   = 4096;
	localparam int ADDR_BITS = 26;
	localparam int COORD_W   = $clog2(MAX_DIM);
	localparam int DIM_W     = COORD_W + 1;

	// Register field widths.
	localparam int RATIO_W    = 29;
	localparam int FRAC_W     = 16;
	localparam int SIZE_W     = 13;
	localparam int STRIDE_W   = 14;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = RATIO_W;

	// Register reset values.
	localparam logic [RATIO_W-1:0]  RATIO_RESET  = RATIO_W'(65536);
	localparam logic [SIZE_W-1:0]   SIZE_RESET   = SIZE_W'(16);
	localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(16);

	// Plane codes; also the raster phase.
	typedef enum logic [1:0] {
		PLANE_Y,
		PLANE_U,
		PLANE_V
	} plane_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH_RATIO,
		REG_HEIGHT_RATIO,
		REG_INPUT_WIDTH,
		REG_INPUT_HEIGHT,
		REG_INPUT_STRIDE,
		REG_OUTPUT_WIDTH,
		REG_OUTPUT_HEIGHT,
		REG_OUTPUT_STRIDE
	} cfg_reg_t;

endpackage

>>> sv/nearest_neighbor_yuv420_scaler.sv
// Each transaction passes through stages 1, 2 and 3 and then the result register.
// Throughput: one transaction per cycle unless out_stall holds the pipeline; the raster
// counters advance in the accept cycle, and the two dependent multiplications sit in
// separate pipeline stages.
// A transaction with zero output width or height yields no result.
// Reset (arst_n low, asynchronous) empties the pipeline, returns the raster to frame start
// and loads the register defaults; there is no clearing pass.
module nearest_neighbor_yuv420_scaler (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write port
	input  logic                                cfg_we,
	input  logic [nnys_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [nnys_pkg::CFG_DATA_W-1:0]     cfg_data,
	// Input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                restart,
	// Output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [nnys_pkg::ADDR_BITS-1:0]      read_address,
	output logic [nnys_pkg::ADDR_BITS-1:0]      write_address,
	output logic [1:0]                          plane,
	output logic                                copy_valid,
	output logic                                frame_last
);

	localparam int COORD_W  = nnys_pkg::COORD_W;
	localparam int DIM_W    = nnys_pkg::DIM_W;
	localparam int AW       = nnys_pkg::ADDR_BITS;
	localparam int RATIO_W  = nnys_pkg::RATIO_W;
	localparam int SIZE_W   = nnys_pkg::SIZE_W;
	localparam int STRIDE_W = nnys_pkg::STRIDE_W;
	localparam int FRAC_W   = nnys_pkg::FRAC_W;

	localparam int RPROD_W    = COORD_W + RATIO_W;
	localparam int YI_W       = RPROD_W - FRAC_W;
	localparam int SRC_Y_W    = YI_W + STRIDE_W;
	localparam int SRC_C_W    = YI_W + SIZE_W;
	localparam int DST_Y_W    = COORD_W + STRIDE_W;
	localparam int DST_C_W    = COORD_W + SIZE_W;
	localparam int PLANE_SZ_W = STRIDE_W + SIZE_W;
	localparam int CHR_SZ_W   = 2 * (SIZE_W - 1);
	localparam int RD_FULL_W  = SRC_Y_W + 1;
	localparam int WR_FULL_W  = (DST_Y_W + 1 > PLANE_SZ_W) ? DST_Y_W + 1 : PLANE_SZ_W;

	// Configuration registers
	logic [RATIO_W-1:0]  width_ratio_q, height_ratio_q;
	logic [SIZE_W-1:0]   input_width_q, input_height_q;
	logic [SIZE_W-1:0]   output_width_q, output_height_q;
	logic [STRIDE_W-1:0] input_stride_q, output_stride_q;

	// Derived plane sizes
	logic [PLANE_SZ_W-1:0] in_y_q, out_y_q;
	logic [CHR_SZ_W-1:0]   in_c_q, out_c_q;
	logic [AW-1:0]         in_uv_q, out_uv_q;

	// Raster state
	logic [COORD_W-1:0]  column_q, row_q;
	nnys_pkg::plane_t    phase_q;

	// Raster step logic
	logic [DIM_W-1:0]    ow_sat, oh_sat, cw, chh, col_inc, row_inc;
	logic [COORD_W-1:0]  pos_col, pos_row, nxt_col, nxt_row;
	nnys_pkg::plane_t    pos_ph, nxt_ph;
	logic                empty, last_c, accept;

	// Pipeline
	logic                en1, en2, en3, out_load;
	logic                v_s1, v_s2, v_s3;
	logic [COORD_W-1:0]  col_s1, row_s1, col_s2, col_s3;
	nnys_pkg::plane_t    ph_s1, ph_s2, ph_s3;
	logic                last_s1, last_s2, last_s3;
	logic [YI_W-1:0]     yi_s2, xi_s2, xi_s3;
	logic [DST_Y_W-1:0]  dy_s2, dy_s3;
	logic [DST_C_W-1:0]  dc_s2, dc_s3;
	logic [SRC_Y_W-1:0]  sy_s3;
	logic [SRC_C_W-1:0]  sc_s3;
	logic [RPROD_W-1:0]  yprod, xprod;

	// Result stage
	logic [RD_FULL_W-1:0] rd_full;
	logic [WR_FULL_W-1:0] wr_full;
	logic [AW-1:0]        rd_c, wr_c;
	logic                 ok_c;
	logic                 out_valid_q, copy_valid_q, frame_last_q;
	logic [AW-1:0]        read_address_q, write_address_q;
	nnys_pkg::plane_t     plane_q;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_ratio_q   <= nnys_pkg::RATIO_RESET;
			height_ratio_q  <= nnys_pkg::RATIO_RESET;
			input_width_q   <= nnys_pkg::SIZE_RESET;
			input_height_q  <= nnys_pkg::SIZE_RESET;
			input_stride_q  <= nnys_pkg::STRIDE_RESET;
			output_width_q  <= nnys_pkg::SIZE_RESET;
			output_height_q <= nnys_pkg::SIZE_RESET;
			output_stride_q <= nnys_pkg::STRIDE_RESET;
		end else if (cfg_we) begin
			unique case (nnys_pkg::cfg_reg_t'(cfg_index))
				nnys_pkg::REG_WIDTH_RATIO:   width_ratio_q   <= cfg_data[RATIO_W-1:0];
				nnys_pkg::REG_HEIGHT_RATIO:  height_ratio_q  <= cfg_data[RATIO_W-1:0];
				nnys_pkg::REG_INPUT_WIDTH:   input_width_q   <= cfg_data[SIZE_W-1:0];
				nnys_pkg::REG_INPUT_HEIGHT:  input_height_q  <= cfg_data[SIZE_W-1:0];
				nnys_pkg::REG_INPUT_STRIDE:  input_stride_q  <= cfg_data[STRIDE_W-1:0];
				nnys_pkg::REG_OUTPUT_WIDTH:  output_width_q  <= cfg_data[SIZE_W-1:0];
				nnys_pkg::REG_OUTPUT_HEIGHT: output_height_q <= cfg_data[SIZE_W-1:0];
				nnys_pkg::REG_OUTPUT_STRIDE: output_stride_q <= cfg_data[STRIDE_W-1:0];
			endcase
		end
	end

	// Plane sizes follow the registers; they are only read in the last stage.
	always_ff @(posedge clk) begin
		in_y_q   <= PLANE_SZ_W'(input_stride_q) * PLANE_SZ_W'(input_height_q);
		out_y_q  <= PLANE_SZ_W'(output_stride_q) * PLANE_SZ_W'(output_height_q);
		in_c_q   <= CHR_SZ_W'(input_width_q >> 1) * CHR_SZ_W'(input_height_q >> 1);
		out_c_q  <= CHR_SZ_W'(output_width_q >> 1) * CHR_SZ_W'(output_height_q >> 1);
		in_uv_q  <= AW'(in_y_q) + AW'(in_c_q);
		out_uv_q <= AW'(out_y_q) + AW'(out_c_q);
	end

	// Saturated output size and chroma raster size.
	always_comb begin
		ow_sat = (32'(output_width_q) > 32'(nnys_pkg::MAX_DIM)) ?
			DIM_W'(nnys_pkg::MAX_DIM) : DIM_W'(output_width_q);
		oh_sat = (32'(output_height_q) > 32'(nnys_pkg::MAX_DIM)) ?
			DIM_W'(nnys_pkg::MAX_DIM) : DIM_W'(output_height_q);
		cw     = ow_sat >> 1;
		chh    = oh_sat >> 1;
		empty  = (ow_sat == '0) || (oh_sat == '0);
	end

	// Raster position for this transaction and the position after it.
	always_comb begin
		pos_col = column_q;
		pos_row = row_q;
		pos_ph  = phase_q;
		if (restart) begin
			pos_col = '0;
			pos_row = '0;
			pos_ph  = nnys_pkg::PLANE_Y;
		end

		// A position outside the current frame restarts at frame start.
		unique case (pos_ph)
			nnys_pkg::PLANE_Y: begin
				if (DIM_W'(pos_row) >= oh_sat || DIM_W'(pos_col) >= ow_sat) begin
					pos_col = '0;
					pos_row = '0;
				end
			end
			nnys_pkg::PLANE_U, nnys_pkg::PLANE_V: begin
				if (DIM_W'(pos_row) >= chh || DIM_W'(pos_col) >= cw) begin
					pos_col = '0;
					pos_row = '0;
					pos_ph  = nnys_pkg::PLANE_Y;
				end
			end
			default: begin
				pos_col = '0;
				pos_row = '0;
				pos_ph  = nnys_pkg::PLANE_Y;
			end
		endcase

		col_inc = DIM_W'(pos_col) + DIM_W'(1);
		row_inc = DIM_W'(pos_row) + DIM_W'(1);
		nxt_col = pos_col;
		nxt_row = pos_row;
		nxt_ph  = pos_ph;

		// Luma runs the full raster; chroma alternates U and V per position.
		unique case (pos_ph)
			nnys_pkg::PLANE_Y: begin
				if (col_inc >= ow_sat) begin
					nxt_col = '0;
					if (row_inc >= oh_sat) begin
						nxt_row = '0;
						nxt_ph  = (cw != '0 && chh != '0) ? nnys_pkg::PLANE_U : nnys_pkg::PLANE_Y;
					end else begin
						nxt_row = COORD_W'(row_inc);
					end
				end else begin
					nxt_col = COORD_W'(col_inc);
				end
			end
			nnys_pkg::PLANE_U: begin
				nxt_ph = nnys_pkg::PLANE_V;
			end
			nnys_pkg::PLANE_V: begin
				nxt_ph = nnys_pkg::PLANE_U;
				if (col_inc >= cw) begin
					nxt_col = '0;
					if (row_inc >= chh) begin
						nxt_row = '0;
						nxt_ph  = nnys_pkg::PLANE_Y;
					end else begin
						nxt_row = COORD_W'(row_inc);
					end
				end else begin
					nxt_col = COORD_W'(col_inc);
				end
			end
			default: begin
				nxt_col = '0;
				nxt_row = '0;
				nxt_ph  = nnys_pkg::PLANE_Y;
			end
		endcase

		if (empty) begin
			nxt_col = '0;
			nxt_row = '0;
			nxt_ph  = nnys_pkg::PLANE_Y;
		end
		last_c = (nxt_ph == nnys_pkg::PLANE_Y) && (nxt_row == '0) && (nxt_col == '0);
	end

	// Each stage loads when it is empty or the stage after it loads.
	always_comb begin
		out_load = !out_valid_q || !out_stall;
		en3      = !v_s3 || out_load;
		en2      = !v_s2 || en3;
		en1      = !v_s1 || en2;
		in_stall = !en1;
		accept   = in_valid && en1;
	end

	// Raster state and stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q    <= '0;
			row_q       <= '0;
			phase_q     <= nnys_pkg::PLANE_Y;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				column_q <= nxt_col;
				row_q    <= nxt_row;
				phase_q  <= nxt_ph;
			end
			if (en1) begin
				v_s1 <= accept && !empty;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (out_load) begin
				out_valid_q <= v_s3;
			end
		end
	end

	// Source coordinates from the Q13.16 ratios.
	always_comb begin
		yprod = RPROD_W'(row_s1) * RPROD_W'(height_ratio_q);
		xprod = RPROD_W'(col_s1) * RPROD_W'(width_ratio_q);
	end

	// Stage 1: emitted raster position; stage 2: coordinates and destination row
	// products; stage 3: source row products.
	always_ff @(posedge clk) begin
		if (en1) begin
			col_s1  <= pos_col;
			row_s1  <= pos_row;
			ph_s1   <= pos_ph;
			last_s1 <= last_c;
		end
		if (en2) begin
			col_s2  <= col_s1;
			ph_s2   <= ph_s1;
			last_s2 <= last_s1;
			yi_s2   <= yprod[RPROD_W-1:FRAC_W];
			xi_s2   <= xprod[RPROD_W-1:FRAC_W];
			dy_s2   <= DST_Y_W'(row_s1) * DST_Y_W'(output_stride_q);
			dc_s2   <= DST_C_W'(row_s1) * DST_C_W'(output_width_q);
		end
		if (en3) begin
			col_s3  <= col_s2;
			ph_s3   <= ph_s2;
			last_s3 <= last_s2;
			xi_s3   <= xi_s2;
			dy_s3   <= dy_s2;
			dc_s3   <= dc_s2;
			sy_s3   <= SRC_Y_W'(yi_s2) * SRC_Y_W'(input_stride_q);
			sc_s3   <= SRC_C_W'(yi_s2) * SRC_C_W'(input_width_q);
		end
	end

	// Final offsets; luma bounds use the full, unwrapped sums.
	always_comb begin
		rd_full = RD_FULL_W'(sy_s3) + RD_FULL_W'(xi_s3);
		wr_full = WR_FULL_W'(dy_s3) + WR_FULL_W'(col_s3);
		rd_c    = AW'(rd_full);
		wr_c    = AW'(wr_full);
		ok_c    = 1'b1;
		case (ph_s3)
			nnys_pkg::PLANE_U: begin
				rd_c = AW'(in_y_q) + AW'(sc_s3 >> 1) + AW'(xi_s3);
				wr_c = AW'(out_y_q) + AW'(dc_s3 >> 1) + AW'(col_s3);
			end
			nnys_pkg::PLANE_V: begin
				rd_c = in_uv_q + AW'(sc_s3 >> 1) + AW'(xi_s3);
				wr_c = out_uv_q + AW'(dc_s3 >> 1) + AW'(col_s3);
			end
			default: begin
				ok_c = (rd_full < RD_FULL_W'(in_y_q)) && (wr_full < WR_FULL_W'(out_y_q));
			end
		endcase
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			read_address_q  <= rd_c;
			write_address_q <= wr_c;
			plane_q         <= ph_s3;
			copy_valid_q    <= ok_c;
			frame_last_q    <= last_s3;
		end
	end

	assign out_valid     = out_valid_q;
	assign read_address  = read_address_q;
	assign write_address = write_address_q;
	assign plane         = plane_q;
	assign copy_valid    = copy_valid_q;
	assign frame_last    = frame_last_q;

	// Only luma copies are ever flagged out of bounds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (plane != nnys_pkg::PLANE_Y) |-> copy_valid)
		else $error("chroma copy flagged as out of bounds");

	// A frame ends on a luma copy or on a V copy, never on a U copy.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_last |-> (plane == nnys_pkg::PLANE_Y) || (plane == nnys_pkg::PLANE_V))
		else $error("frame end marked on a U copy");

	// An empty first stage never holds off the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !in_stall)
		else $error("input stalled with an empty first stage");

	// A restart transaction is emitted at frame start.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && restart && !empty |=>
		v_s1 && (col_s1 == '0) && (row_s1 == '0) && (ph_s1 == nnys_pkg::PLANE_Y))
		else $error("restart did not begin at frame start");

endmodule
